FILE: design/smi_pkg.sv
// Package: constants, state codes and shared types of the symmetric matrix inverter.
package smi_pkg;

    localparam int SMI_MAX_ORDER   = 8;
    localparam int SMI_DATA_WIDTH  = 32;
    localparam int SMI_FRAC_BITS   = 16;
    localparam int SMI_ORDER_WIDTH = 4;
    localparam logic [SMI_ORDER_WIDTH-1:0] SMI_ORDER_RESET = 4'd8;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_W,
        S_GET_W,
        S_RD_G,
        S_GET_G,
        S_DIV,
        S_RD_A,
        S_MUL,
        S_ADD,
        S_RC_GO,
        S_RC,
        S_CP,
        S_OUT_RD,
        S_OUT_WAIT,
        S_OUT_SEND
    } t_state;

    typedef struct packed {
        logic done;
        logic err;
    } t_div_rsp;

endpackage

FILE: design/smi_if.sv
// Interfaces: input entry, output entry and configuration channels.
interface smi_in_if #(parameter int DATA_WIDTH = smi_pkg::SMI_DATA_WIDTH);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] matrix_entry;
    modport source (output valid, output matrix_entry, input ready);
    modport sink   (input valid, input matrix_entry, output ready);
endinterface

interface smi_out_if #(parameter int DATA_WIDTH = smi_pkg::SMI_DATA_WIDTH);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] inverse_entry;
    logic                         last_of_matrix;
    logic                         numeric_error;
    modport source (output valid, output inverse_entry, output last_of_matrix,
                    output numeric_error, input ready);
    modport sink   (input valid, input inverse_entry, input last_of_matrix,
                    input numeric_error, output ready);
endinterface

interface smi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [smi_pkg::SMI_ORDER_WIDTH-1:0]  matrix_order;
    modport source (output valid, output matrix_order, input ready);
    modport sink   (input valid, input matrix_order, output ready);
endinterface

FILE: design/smi_div.sv
// Restoring divider, one quotient bit per cycle, signed result saturated to the data width.
module smi_div #(
    parameter int DATA_WIDTH = smi_pkg::SMI_DATA_WIDTH,
    parameter int QUOT_WIDTH = 2 * smi_pkg::SMI_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [QUOT_WIDTH:0]   i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output smi_pkg::t_div_rsp            o_rsp,
    output logic [DATA_WIDTH-1:0]        o_quot
);
    import smi_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int QW   = QUOT_WIDTH;
    localparam int CNTW = $clog2(QW);
    localparam logic [QW-1:0] LIM_POS = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = LIM_POS + QW'(1);
    localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    logic            r_busy;
    logic            r_fin;
    logic [CNTW-1:0] r_cnt;
    logic [QW-1:0]   r_q;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic            r_neg;
    logic [DW-1:0]   r_quot;
    t_div_rsp        r_rsp;

    logic [QW:0]   num_neg;
    logic [QW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] sat_val;
    logic          sat_err;

    always_comb begin
        num_neg = -i_num;
        num_mag = i_num[QW] ? num_neg[QW-1:0] : i_num[QW-1:0];
        den_mag = i_den[DW-1] ? DW'(-i_den) : i_den;
        trial   = {r_rem, r_q[QW-1]};
        diff    = trial - {1'b0, r_den};
        ge      = (trial >= {1'b0, r_den});
        sat_err = 1'b0;
        if (r_neg) begin
            if (r_q > LIM_NEG) begin
                sat_val = VAL_MIN;
                sat_err = 1'b1;
            end else begin
                sat_val = -r_q[DW-1:0];
            end
        end else begin
            if (r_q > LIM_POS) begin
                sat_val = VAL_MAX;
                sat_err = 1'b1;
            end else begin
                sat_val = r_q[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rsp  <= '0;
        end else begin
            r_rsp <= '0;
            r_fin <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_rsp  <= '{done: 1'b1, err: 1'b1};
                    r_quot <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_q    <= num_mag;
                    r_rem  <= '0;
                    r_den  <= den_mag;
                    r_neg  <= i_num[QW] ^ i_den[DW-1];
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_q   <= {r_q[QW-2:0], ge};
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_quot <= sat_val;
                r_rsp  <= '{done: 1'b1, err: sat_err};
            end
        end
    end

    assign o_rsp  = r_rsp;
    assign o_quot = r_quot;

endmodule

FILE: design/symmetric_matrix_inverse.sv
// Top level: in-place inversion of a symmetric positive-definite Q16.16 matrix.
//
//  channel   dir   payload                                          moves
//  i_in      in    matrix_entry                                     one entry, row-major
//  o_out     out   inverse_entry, last_of_matrix, numeric_error     one inverse entry
//  i_cfg     in    matrix_order                                     order register write
//
//  Load takes one entry per cycle while i_in is valid (n*n transfers). The compute phase runs
//  n passes through one multiplier, one adder and one shared restoring divider, which
//  takes QW = DATA_WIDTH+16 steps per quotient. Release reads each result, waits for the
//  registered memory read and then offers the result on o_out.
//  No matrix entry is taken during compute or release. Reset is synchronous and active low; the
//  work store is not cleared. A stalled output holds its entry and the sequencer waits.
module symmetric_matrix_inverse #(
    parameter int MAX_ORDER  = smi_pkg::SMI_MAX_ORDER,
    parameter int DATA_WIDTH = smi_pkg::SMI_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smi_in_if.sink    i_in,
    smi_out_if.source o_out,
    smi_cfg_if.sink   i_cfg
);
    import smi_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = SMI_FRAC_BITS;
    localparam int QW   = (DW + FB > 2 * FB) ? DW + FB : 2 * FB + 1;
    localparam int CW   = $clog2(MAX_ORDER + 1);
    localparam int IW   = $clog2(MAX_ORDER);
    localparam int AW   = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int OW   = SMI_ORDER_WIDTH;
    localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] row, input logic [CW-1:0] col);
        return AW'(int'(row) * MAX_ORDER + int'(col));
    endfunction

    // Work store, one write and one registered read per cycle
    logic [DW-1:0] work_mem [MAX_ORDER*MAX_ORDER];
    logic [DW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [DW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            work_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= work_mem[mem_ra];
    end

    // Pivot quotients of the current pass
    logic [DW-1:0] r_pivot [MAX_ORDER];
    logic          piv_we;
    logic [DW-1:0] piv_wd;

    t_state                r_state, n_state;
    logic [OW-1:0]         r_order, n_order;
    logic [CW-1:0]         r_row, n_row, r_col, n_col;
    logic [CW-1:0]         r_k, n_k, r_i, n_i, r_j, n_j;
    logic                  r_err, n_err;
    logic signed [DW-1:0]  r_w, n_w, r_g, n_g, r_a, n_a;
    logic signed [2*DW-1:0] r_prod, n_prod;
    logic [DW-1:0]         r_odata, n_odata;

    logic [CW-1:0]         n_eff;
    logic                  div_start;
    logic signed [QW:0]    div_num;
    t_div_rsp              div_rsp;
    logic [DW-1:0]         div_quot;

    logic signed [2*DW-1:0] prod_sh;
    logic                   prod_ovf;
    logic signed [DW-1:0]   prod_sat;
    logic signed [DW:0]     sum;
    logic                   sum_ovf;
    logic [DW-1:0]          sum_sat;
    logic [DW-1:0]          piv_b;
    logic                   neg_err;
    logic [CW:0]            ik_sum;
    logic                   out_last;
    logic [CW-1:0]          out_hi, out_lo;

    smi_div #(
        .DATA_WIDTH (DW),
        .QUOT_WIDTH (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_w),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    // Clamp the order register into 1..MAX_ORDER
    always_comb begin
        if (r_order == '0) begin
            n_eff = CW'(1);
        end else if (r_order > OW'(MAX_ORDER)) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = CW'(r_order);
        end
    end

    // Datapath: floor-shifted saturated product, saturated sum, saturated negation
    always_comb begin
        prod_sh  = r_prod >>> FB;
        prod_ovf = !((&prod_sh[2*DW-1:DW-1]) || !(|prod_sh[2*DW-1:DW-1]));
        prod_sat = prod_ovf ? (prod_sh[2*DW-1] ? VAL_MIN : VAL_MAX) : prod_sh[DW-1:0];
        sum      = {r_a[DW-1], r_a} + {prod_sat[DW-1], prod_sat};
        sum_ovf  = sum[DW] ^ sum[DW-1];
        sum_sat  = sum_ovf ? (sum[DW] ? VAL_MIN : VAL_MAX) : sum[DW-1:0];
        ik_sum   = {1'b0, r_i} + {1'b0, r_k};
        neg_err  = 1'b0;
        piv_b    = div_quot;
        // negate the quotient while the row still lies inside the shrinking block
        if (ik_sum < {1'b0, n_eff}) begin
            if (div_quot == VAL_MIN) begin
                piv_b   = VAL_MAX;
                neg_err = 1'b1;
            end else begin
                piv_b = -div_quot;
            end
        end
        out_hi   = (r_row >= r_col) ? r_row : r_col;
        out_lo   = (r_row >= r_col) ? r_col : r_row;
        out_last = (r_row == n_eff - CW'(1)) && (r_col == n_eff - CW'(1));
    end

    // Sequencer: next state, counters and memory control
    always_comb begin
        n_state   = r_state;
        n_order   = r_order;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_err     = r_err;
        n_w       = r_w;
        n_g       = r_g;
        n_a       = r_a;
        n_prod    = r_prod;
        n_odata   = r_odata;
        mem_we    = 1'b0;
        mem_wa    = f_addr(r_row, r_col);
        mem_wd    = i_in.matrix_entry;
        mem_ra    = f_addr(r_i, '0);
        piv_we    = 1'b0;
        piv_wd    = piv_b;
        div_start = 1'b0;
        div_num   = (QW + 1)'(r_g) <<< FB;

        unique case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    mem_we = 1'b1;
                    if (r_col == n_eff - CW'(1)) begin
                        n_col = '0;
                        if (r_row == n_eff - CW'(1)) begin
                            n_row   = '0;
                            n_k     = '0;
                            n_state = S_RD_W;
                        end else begin
                            n_row = r_row + CW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            S_RD_W: begin
                mem_ra  = f_addr('0, '0);
                n_state = S_GET_W;
            end
            S_GET_W: begin
                n_w = r_rdata;
                n_i = CW'(1);
                n_state = (n_eff > CW'(1)) ? S_RD_G : S_RC_GO;
            end
            S_RD_G: begin
                mem_ra  = f_addr(r_i, '0);
                n_state = S_GET_G;
            end
            S_GET_G: begin
                n_g       = r_rdata;
                div_start = 1'b1;
                div_num   = (QW + 1)'($signed(r_rdata)) <<< FB;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    piv_we  = 1'b1;
                    n_err   = r_err | div_rsp.err | neg_err;
                    n_j     = CW'(1);
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                mem_ra  = f_addr(r_i, r_j);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_a     = r_rdata;
                n_prod  = r_g * $signed(r_pivot[r_j[IW-1:0]]);
                n_state = S_ADD;
            end
            S_ADD: begin
                mem_we = 1'b1;
                mem_wa = f_addr(r_i - CW'(1), r_j - CW'(1));
                mem_wd = sum_sat;
                n_err  = r_err | prod_ovf | sum_ovf;
                if (r_j == r_i) begin
                    if (r_i == n_eff - CW'(1)) begin
                        n_state = S_RC_GO;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_RD_G;
                    end
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_RD_A;
                end
            end
            S_RC_GO: begin
                div_start = 1'b1;
                div_num   = (QW + 1)'(1) <<< (2 * FB);
                n_state   = S_RC;
            end
            S_RC: begin
                if (div_rsp.done) begin
                    mem_we = 1'b1;
                    mem_wa = f_addr(n_eff - CW'(1), n_eff - CW'(1));
                    mem_wd = div_quot;
                    n_err  = r_err | div_rsp.err;
                    n_i    = CW'(1);
                    if (n_eff > CW'(1)) begin
                        n_state = S_CP;
                    end else if (r_k == n_eff - CW'(1)) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RD_W;
                    end
                end
            end
            S_CP: begin
                // drop the pivot quotients into the last row
                mem_we = 1'b1;
                mem_wa = f_addr(n_eff - CW'(1), r_i - CW'(1));
                mem_wd = r_pivot[r_i[IW-1:0]];
                if (r_i == n_eff - CW'(1)) begin
                    if (r_k == n_eff - CW'(1)) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RD_W;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_OUT_RD: begin
                // mirror: read the lower triangle for entries above the diagonal
                mem_ra  = f_addr(out_hi, out_lo);
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                n_odata = r_rdata;
                n_state = S_OUT_SEND;
            end
            S_OUT_SEND: begin
                if (o_out.ready) begin
                    if (out_last) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_err   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OUT_RD;
                        if (r_col == n_eff - CW'(1)) begin
                            n_col = '0;
                            n_row = r_row + CW'(1);
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // an order write restarts loading
        if (i_cfg.valid) begin
            n_order = i_cfg.matrix_order;
            n_row   = '0;
            n_col   = '0;
            n_err   = 1'b0;
            n_state = S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_order <= SMI_ORDER_RESET;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_g     <= n_g;
        r_a     <= n_a;
        r_prod  <= n_prod;
        r_odata <= n_odata;
        if (piv_we) begin
            r_pivot[r_i[IW-1:0]] <= piv_wd;
        end
    end

    assign i_in.ready           = (r_state == S_LOAD);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = (r_state == S_OUT_SEND);
    assign o_out.inverse_entry  = r_odata;
    assign o_out.last_of_matrix = out_last;
    assign o_out.numeric_error  = r_err;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is offered");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV || r_state == S_RC))
        else $error("divider finished outside a divide wait");

    a_release_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_matrix && !i_cfg.valid)
        |=> (r_state == S_LOAD && !r_err && r_row == '0 && r_col == '0))
        else $error("block not back to loading after the last result");

endmodule
